>>> src/ptc_pkg.sv
// Shared types and constants for the pressure and temperature compensation block.
package ptc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_SENS     = 3'd0;
    localparam logic [2:0] REG_OFF      = 3'd1;
    localparam logic [2:0] REG_TCS      = 3'd2;
    localparam logic [2:0] REG_TCO      = 3'd3;
    localparam logic [2:0] REG_TREF     = 3'd4;
    localparam logic [2:0] REG_TEMPSENS = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Pipeline depth, input register through output register
    localparam int NUM_STAGES = 9;

    // 20.00 C reference and the limits of the valid range
    localparam logic signed [20:0] TEMP_REF = 21'sd2000;
    localparam logic signed [32:0] P_MIN    = 33'sd1000;
    localparam logic signed [32:0] P_MAX    = 33'sd200000;
    localparam logic signed [21:0] T_MIN    = -22'sd4000;
    localparam logic signed [21:0] T_MAX    = 22'sd8500;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] pressure_centimbar;
        logic signed [31:0] temperature_centideg;
        logic               valid_res;
    } result_t;

endpackage

>>> src/pressure_temperature_compensation.sv
// Pressure and temperature compensation pipeline, top level.
//
// Takes one raw pressure / temperature word per cycle when the input is not stalled
// and returns compensated pressure (0.01 mbar) and temperature (0.01 C) with a
// range flag. The block is a nine-stage pipeline: one result word leaves per cycle
// when the output is not stalled, and each word passes through stage registers 1
// to 8 into the output register; a stall can hold it at any stage.
// Stage boundaries follow the multipliers: the temperature products,
// the square of the temperature delta, and the pressure product, which is split
// into two narrow partial products and summed one stage later. Each stage holds
// its word until the next stage has room, so bubbles collapse and a stalled
// output does not stop input until all stages are full. Calibration registers
// are read directly by the stages and must be written while the pipeline is empty.
module pressure_temperature_compensation (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  ptc_pkg::sample_t                      sample,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output ptc_pkg::result_t                      result
);

    localparam int NS = ptc_pkg::NUM_STAGES;

    // Calibration words
    logic [15:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    // Stage control
    logic [NS:1] v_reg;
    logic [NS:1] v_next;
    logic [NS:1] ready;
    logic [NS:1] stage_in;
    logic [NS:1] load;

    // Stage 1: raw pressure, temperature difference, nonzero flag
    logic [23:0]        s1_d1_reg;
    logic signed [25:0] s1_dt_reg;
    logic               s1_nz_reg;
    logic signed [25:0] s1_dt_next;

    // Stage 2: products of the temperature difference
    logic [23:0]        s2_d1_reg;
    logic               s2_nz_reg;
    logic signed [42:0] s2_p6_reg, s2_p4_reg, s2_p3_reg;
    logic signed [51:0] s2_dtsq_reg;
    logic signed [42:0] s2_p6_next, s2_p4_next, s2_p3_next;
    logic signed [51:0] s2_dtsq_next;

    // Stage 3: first-order terms
    logic [23:0]        s3_d1_reg;
    logic               s3_nz_reg;
    logic signed [19:0] s3_delta_reg;
    logic signed [20:0] s3_temp_reg;
    logic [41:0]        s3_off_reg, s3_sens_reg;
    logic [20:0]        s3_tcorr_reg;
    logic signed [19:0] s3_delta_next;
    logic signed [20:0] s3_temp_next;
    logic [41:0]        s3_off_next, s3_sens_next;
    logic [55:0]        s3_tc_sum;

    // Stage 4: square of the delta
    logic [23:0]        s4_d1_reg;
    logic               s4_nz_reg;
    logic               s4_low_reg;
    logic signed [20:0] s4_temp_reg;
    logic [41:0]        s4_off_reg, s4_sens_reg;
    logic [20:0]        s4_tcorr_reg;
    logic signed [39:0] s4_dsq_reg;
    logic signed [39:0] s4_dsq_next;

    // Stage 5: second-order corrected terms
    logic [23:0]        s5_d1_reg;
    logic               s5_nz_reg;
    logic signed [21:0] s5_temp_reg;
    logic [41:0]        s5_off_reg, s5_sens_reg;
    logic [44:0]        s5_oc_full;
    logic [45:0]        s5_sc_full;
    logic [41:0]        s5_oc, s5_sc;
    logic signed [21:0] s5_temp_next;
    logic [41:0]        s5_off_next, s5_sens_next;

    // Stage 6: pressure partial products
    logic               s6_nz_reg;
    logic signed [21:0] s6_temp_reg;
    logic [41:0]        s6_off_reg;
    logic [44:0]        s6_pplo_reg;
    logic signed [45:0] s6_pphi_reg;
    logic [44:0]        s6_pplo_next;
    logic signed [45:0] s6_pphi_next;

    // Stage 7: full pressure product
    logic               s7_nz_reg;
    logic signed [21:0] s7_temp_reg;
    logic [41:0]        s7_off_reg;
    logic [67:0]        s7_prod_reg;
    logic [67:0]        s7_prod_next;

    // Stage 8: pressure
    logic               s8_nz_reg;
    logic signed [21:0] s8_temp_reg;
    logic signed [32:0] s8_p_reg;
    logic [47:0]        s8_diff;

    // Stage 9: output register
    ptc_pkg::result_t   out_reg;
    ptc_pkg::result_t   out_next;

    // Write calibration words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptc_pkg::REG_SENS:     c1_reg <= cfg_data;
                ptc_pkg::REG_OFF:      c2_reg <= cfg_data;
                ptc_pkg::REG_TCS:      c3_reg <= cfg_data;
                ptc_pkg::REG_TCO:      c4_reg <= cfg_data;
                ptc_pkg::REG_TREF:     c5_reg <= cfg_data;
                ptc_pkg::REG_TEMPSENS: c6_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        ready[NS] = !v_reg[NS] || !result_stall;
        for (int k = NS - 1; k >= 1; k--)
        begin
            ready[k] = !v_reg[k] || ready[k + 1];
        end
        stage_in = {v_reg[NS-1:1], sample_valid};
        load     = ready & stage_in;
        for (int k = 1; k <= NS; k++)
        begin
            v_next[k] = ready[k] ? stage_in[k] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign sample_stall = !ready[1];
    assign result_valid = v_reg[NS];
    assign result       = out_reg;

    // Stage datapath
    always_comb
    begin
        // dT = D2 - C5 * 2^8
        s1_dt_next = $signed({2'b00, sample.raw_temperature})
                   - $signed({2'b00, c5_reg, 8'b0});

        // products against the calibration words
        s2_p6_next   = s1_dt_reg * $signed({1'b0, c6_reg});
        s2_p4_next   = s1_dt_reg * $signed({1'b0, c4_reg});
        s2_p3_next   = s1_dt_reg * $signed({1'b0, c3_reg});
        s2_dtsq_next = s1_dt_reg * s1_dt_reg;

        // shifts by dropping low bits; 11 * dT^2 by shift and add
        s3_delta_next = s2_p6_reg[42:23];
        s3_temp_next  = $signed({s3_delta_next[19], s3_delta_next}) + ptc_pkg::TEMP_REF;
        s3_off_next   = {9'b0, c2_reg, 17'b0} + {{5{s2_p4_reg[42]}}, s2_p4_reg[42:6]};
        s3_sens_next  = {10'b0, c1_reg, 16'b0} + {{6{s2_p3_reg[42]}}, s2_p3_reg[42:7]};
        s3_tc_sum     = {1'b0, s2_dtsq_reg, 3'b0} + {3'b0, s2_dtsq_reg, 1'b0}
                      + {4'b0, s2_dtsq_reg};

        // square the delta
        s4_dsq_next = s3_delta_reg * s3_delta_reg;

        // apply the low-temperature correction
        s5_oc_full   = {s4_dsq_reg, 5'b0} - {5'b0, s4_dsq_reg};
        s5_sc_full   = {s4_dsq_reg, 6'b0} - {6'b0, s4_dsq_reg};
        s5_oc        = s5_oc_full[44:3];
        s5_sc        = {1'b0, s5_sc_full[45:5]};
        s5_off_next  = s4_low_reg ? (s4_off_reg - s5_oc) : s4_off_reg;
        s5_sens_next = s4_low_reg ? (s4_sens_reg - s5_sc) : s4_sens_reg;
        s5_temp_next = s4_low_reg
                     ? ($signed({s4_temp_reg[20], s4_temp_reg}) - $signed({1'b0, s4_tcorr_reg}))
                     : $signed({s4_temp_reg[20], s4_temp_reg});

        // split SENS into a signed high half and an unsigned low half
        s6_pplo_next = s5_d1_reg * s5_sens_reg[20:0];
        s6_pphi_next = $signed({1'b0, s5_d1_reg}) * $signed(s5_sens_reg[41:21]);

        // recombine the partial products
        s7_prod_next = {s6_pphi_reg[45], s6_pphi_reg, 21'b0} + {23'b0, s6_pplo_reg};

        // P = (D1 * SENS / 2^21 - OFF) / 2^15
        s8_diff = {s7_prod_reg[67], s7_prod_reg[67:21]} - {{6{s7_off_reg[41]}}, s7_off_reg};

        // range check and format the result word
        out_next.pressure_centimbar   = s8_p_reg[31:0];
        out_next.temperature_centideg = {{10{s8_temp_reg[21]}}, s8_temp_reg};
        out_next.valid_res = s8_nz_reg
                          && (s8_p_reg >= ptc_pkg::P_MIN) && (s8_p_reg <= ptc_pkg::P_MAX)
                          && (s8_temp_reg >= ptc_pkg::T_MIN)
                          && (s8_temp_reg <= ptc_pkg::T_MAX);
    end

    // Stage registers, loaded when a word moves in
    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s1_d1_reg <= sample.raw_pressure;
            s1_dt_reg <= s1_dt_next;
            s1_nz_reg <= (sample.raw_pressure != '0) && (sample.raw_temperature != '0);
        end
        if (load[2])
        begin
            s2_d1_reg   <= s1_d1_reg;
            s2_nz_reg   <= s1_nz_reg;
            s2_p6_reg   <= s2_p6_next;
            s2_p4_reg   <= s2_p4_next;
            s2_p3_reg   <= s2_p3_next;
            s2_dtsq_reg <= s2_dtsq_next;
        end
        if (load[3])
        begin
            s3_d1_reg    <= s2_d1_reg;
            s3_nz_reg    <= s2_nz_reg;
            s3_delta_reg <= s3_delta_next;
            s3_temp_reg  <= s3_temp_next;
            s3_off_reg   <= s3_off_next;
            s3_sens_reg  <= s3_sens_next;
            s3_tcorr_reg <= s3_tc_sum[55:35];
        end
        if (load[4])
        begin
            s4_d1_reg    <= s3_d1_reg;
            s4_nz_reg    <= s3_nz_reg;
            s4_low_reg   <= s3_delta_reg[19];
            s4_temp_reg  <= s3_temp_reg;
            s4_off_reg   <= s3_off_reg;
            s4_sens_reg  <= s3_sens_reg;
            s4_tcorr_reg <= s3_tcorr_reg;
            s4_dsq_reg   <= s4_dsq_next;
        end
        if (load[5])
        begin
            s5_d1_reg   <= s4_d1_reg;
            s5_nz_reg   <= s4_nz_reg;
            s5_temp_reg <= s5_temp_next;
            s5_off_reg  <= s5_off_next;
            s5_sens_reg <= s5_sens_next;
        end
        if (load[6])
        begin
            s6_nz_reg   <= s5_nz_reg;
            s6_temp_reg <= s5_temp_reg;
            s6_off_reg  <= s5_off_reg;
            s6_pplo_reg <= s6_pplo_next;
            s6_pphi_reg <= s6_pphi_next;
        end
        if (load[7])
        begin
            s7_nz_reg   <= s6_nz_reg;
            s7_temp_reg <= s6_temp_reg;
            s7_off_reg  <= s6_off_reg;
            s7_prod_reg <= s7_prod_next;
        end
        if (load[8])
        begin
            s8_nz_reg   <= s7_nz_reg;
            s8_temp_reg <= s7_temp_reg;
            s8_p_reg    <= s8_diff[47:15];
        end
        if (load[9])
        begin
            out_reg <= out_next;
        end
    end

endmodule

>>> verif/ptc_checker.sv
// Checker for the compensation block: tracks calibration writes, predicts results, compares them.
module ptc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           sample_valid,
    input  logic                           sample_stall,
    input  ptc_pkg::sample_t               sample,
    input  logic                           result_valid,
    input  logic                           result_stall,
    input  ptc_pkg::result_t               result,
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_COEFS  = 6;
    localparam int MAX_REPORT = 10;

    // Limits of the valid range, in 0.01 mbar and 0.01 C
    localparam longint TEMP_REF_CD = 2000;
    localparam longint P_LO_CMBAR  = 1000;
    localparam longint P_HI_CMBAR  = 200000;
    localparam longint T_LO_CD     = -4000;
    localparam longint T_HI_CD     = 8500;

    logic [ptc_pkg::CFG_DATA_W-1:0] cal [NUM_COEFS];
    ptc_pkg::result_t               expected_results [$];
    int                             fail_count;

    // Second-order compensation of one raw pair with the current calibration words
    function automatic ptc_pkg::result_t compensate(input ptc_pkg::sample_t s);
        longint  d1;
        longint  d2;
        longint  c1;
        longint  c2;
        longint  c3;
        longint  c4;
        longint  c5;
        longint  c6;
        longint  dt;
        longint  temp;
        longint  off;
        longint  sens;
        longint  delta;
        longint  p;
        ptc_pkg::result_t r;
        d1 = longint'(s.raw_pressure);
        d2 = longint'(s.raw_temperature);
        c1 = longint'(cal[ptc_pkg::REG_SENS]);
        c2 = longint'(cal[ptc_pkg::REG_OFF]);
        c3 = longint'(cal[ptc_pkg::REG_TCS]);
        c4 = longint'(cal[ptc_pkg::REG_TCO]);
        c5 = longint'(cal[ptc_pkg::REG_TREF]);
        c6 = longint'(cal[ptc_pkg::REG_TEMPSENS]);

        // First order; >>> on signed operands floors like the sensor math
        dt   = d2 - c5 * 256;
        temp = TEMP_REF_CD + ((dt * c6) >>> 23);
        off  = c2 * 131072 + ((c4 * dt) >>> 6);
        sens = c1 * 65536 + ((c3 * dt) >>> 7);

        // Cold correction, delta taken before temp is adjusted
        if (temp < TEMP_REF_CD)
        begin
            delta = temp - TEMP_REF_CD;
            temp  = temp - ((11 * dt * dt) >>> 35);
            off   = off - ((31 * delta * delta) >>> 3);
            sens  = sens - ((63 * delta * delta) >>> 5);
        end

        p = (((d1 * sens) >>> 21) - off) >>> 15;

        r.pressure_centimbar   = p[31:0];
        r.temperature_centideg = temp[31:0];
        r.valid_res            = (d1 != 0) && (d2 != 0) &&
                                 (p >= P_LO_CMBAR) && (p <= P_HI_CMBAR) &&
                                 (temp >= T_LO_CD) && (temp <= T_HI_CD);
        return r;
    endfunction

    // Follow writes, check each result word against the oldest prediction, queue new ones
    always @(posedge clk or negedge rst_n)
    begin : watch
        ptc_pkg::result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                cal[i] <= '0;
            end
            expected_results.delete();
            fail_count = 0;
            errors     <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we && cfg_index <= ptc_pkg::REG_TEMPSENS)
            begin
                cal[cfg_index] <= cfg_data;
            end

            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORT)
                    begin
                        $display("%0t: unexpected result word p=%0d t=%0d ok=%0b", $realtime,
                                 $signed(result.pressure_centimbar),
                                 $signed(result.temperature_centideg), result.valid_res);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.pressure_centimbar !== want.pressure_centimbar ||
                        result.temperature_centideg !== want.temperature_centideg ||
                        result.valid_res !== want.valid_res)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORT)
                        begin
                            $display("%0t: mismatch exp p=%0d t=%0d ok=%0b got p=%0d t=%0d ok=%0b",
                                     $realtime, $signed(want.pressure_centimbar),
                                     $signed(want.temperature_centideg), want.valid_res,
                                     $signed(result.pressure_centimbar),
                                     $signed(result.temperature_centideg), result.valid_res);
                        end
                    end
                end
            end

            if (sample_valid && !sample_stall)
            begin
                expected_results.push_back(compensate(sample));
            end

            pending <= expected_results.size();
            errors  <= fail_count;
        end
    end

endmodule

>>> verif/tb_pressure_temperature_compensation.sv
// Top of the compensation testbench: clock, reset, calibration loads, sample words and verdict.
module tb_pressure_temperature_compensation;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_COEFS      = 6;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 240;
    localparam int MAX_WAIT       = 18;
    localparam int HOLD_CYCLES    = 150;
    localparam int BURST_ITEMS    = 60;
    localparam logic [23:0] RAW_MAX = 24'hFFFFFF;

    // Indexes past the last coefficient, written to check they are dropped
    localparam logic [ptc_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [ptc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef enum int {CAL_TYPICAL, CAL_RANDOM, CAL_MAX, CAL_ZERO} cal_kind_t;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           cfg_we       = 1'b0;
    logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [ptc_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    logic                           sample_valid = 1'b0;
    logic                           sample_stall;
    ptc_pkg::sample_t               sample       = '0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    ptc_pkg::result_t               result;
    int                             errors;
    int                             pending;

    logic [ptc_pkg::CFG_DATA_W-1:0] cur_cal [NUM_COEFS];
    int                             snd_idle;
    int                             rcv_idle;
    int                             hold_off_cycles = 0;

    cal_kind_t phase_cal [NUM_PHASES] =
        '{CAL_TYPICAL, CAL_RANDOM, CAL_MAX, CAL_ZERO, CAL_RANDOM, CAL_TYPICAL};
    int        phase_snd [NUM_PHASES] = '{1, 2, 0, 2, 0, 1};
    int        phase_rcv [NUM_PHASES] = '{1, 2, 2, 0, 0, 1};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    pressure_temperature_compensation u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    ptc_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    // Idle cycles before the next word: none, occasional, or always drawn
    function automatic int draw_wait(input int level);
        if (level == 0)
            return 0;
        if (level == 1)
            return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, MAX_WAIT)) : 0;
        return int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic logic [23:0] corner_word();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return RAW_MAX;
            2:       return 24'd1 << $urandom_range(0, 23);
            default: return 24'($urandom);
        endcase
    endfunction

    // Offer one sample word and hold it until it is taken
    task automatic send_sample(input logic [23:0] p, input logic [23:0] t);
        int               gap;
        ptc_pkg::sample_t s;
        gap = draw_wait(snd_idle);
        s.raw_pressure    = p;
        s.raw_temperature = t;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
    endtask

    // Stop offering and wait until every predicted word has come back
    task automatic drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Pick a calibration set and write all six words plus a spare index
    task automatic load_cal(input cal_kind_t kind);
        for (int i = 0; i < NUM_COEFS; i++)
        begin
            case (kind)
                CAL_TYPICAL: cur_cal[i] = '0;
                CAL_RANDOM:  cur_cal[i] = 16'($urandom);
                CAL_MAX:     cur_cal[i] = '1;
                default:     cur_cal[i] = '0;
            endcase
        end
        if (kind == CAL_TYPICAL)
        begin
            cur_cal[ptc_pkg::REG_SENS]     = 16'd34982;
            cur_cal[ptc_pkg::REG_OFF]      = 16'd36352;
            cur_cal[ptc_pkg::REG_TCS]      = 16'd20328;
            cur_cal[ptc_pkg::REG_TCO]      = 16'd22354;
            cur_cal[ptc_pkg::REG_TREF]     = 16'd26646;
            cur_cal[ptc_pkg::REG_TEMPSENS] = 16'd26146;
        end
        for (int i = 0; i < NUM_COEFS; i++)
        begin
            cfg_we   <= 1'b1;
            cfg_data <= cur_cal[i];
            case (i)
                0:       cfg_index <= ptc_pkg::REG_SENS;
                1:       cfg_index <= ptc_pkg::REG_OFF;
                2:       cfg_index <= ptc_pkg::REG_TCS;
                3:       cfg_index <= ptc_pkg::REG_TCO;
                4:       cfg_index <= ptc_pkg::REG_TREF;
                default: cfg_index <= ptc_pkg::REG_TEMPSENS;
            endcase
            @(posedge clk);
        end
        cfg_index <= $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
        cfg_data  <= 16'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly readings near the reference temperature, plus noise, corners and cold readings
    task automatic send_random();
        int          base;
        int          t;
        logic [23:0] p;
        base = int'(cur_cal[ptc_pkg::REG_TREF]) * 256;
        case ($urandom_range(0, 9))
            6, 7:
            begin
                p = 24'($urandom);
                t = int'($urandom_range(0, RAW_MAX));
            end
            8:
            begin
                p = corner_word();
                t = int'(corner_word());
            end
            9:
            begin
                p = 24'($urandom_range(1 << 21, RAW_MAX));
                t = base - int'($urandom_range(0, 1 << 23));
            end
            default:
            begin
                p = 24'($urandom_range(1 << 21, RAW_MAX));
                t = base + int'($urandom_range(0, 1 << 21)) - (1 << 20);
            end
        endcase
        if (t < 0)
            t = 0;
        if (t > int'(RAW_MAX))
            t = int'(RAW_MAX);
        send_sample(p, t[23:0]);
    endtask

    // Drive the result stall: random waits, or a long hold when one is requested
    initial
    begin : result_sink
        int n;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else
            begin
                n = draw_wait(rcv_idle);
            end
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int tref_word;
        snd_idle = 1;
        rcv_idle = 1;
        for (int i = 0; i < NUM_COEFS; i++)
        begin
            cur_cal[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: everything collapses to zero pressure at 20.00 C
        send_sample(24'd0, 24'd0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(24'd7360000, 24'd6900000);
        drain();

        // Directed words on a typical calibration set
        load_cal(CAL_TYPICAL);
        tref_word = int'(cur_cal[ptc_pkg::REG_TREF]) * 256;
        send_sample(24'd0, 24'd6900000);
        send_sample(24'd7360000, 24'd0);
        send_sample(24'd0, 24'd0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(RAW_MAX, 24'd1);
        send_sample(24'd1, RAW_MAX);
        send_sample(24'd1, 24'd1);
        send_sample(24'd7360000, 24'd6900000);
        send_sample(24'd7360000, tref_word[23:0]);
        send_sample(24'd7360000, 24'(tref_word - 1));
        send_sample(24'd7360000, 24'(tref_word - 300000));
        send_sample(24'd7360000, 24'(tref_word - 3000000));
        send_sample(24'd7360000, 24'(tref_word + 4000000));
        send_sample(24'd100000, 24'd6900000);
        send_sample(RAW_MAX, 24'd6900000);
        send_sample(24'd5000000, 24'd6821000);
        send_sample(24'd9000000, 24'd6700000);
        drain();

        // Random phases, one calibration set and idle pattern each
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            load_cal(phase_cal[ph]);
            snd_idle = phase_snd[ph];
            rcv_idle = phase_rcv[ph];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Hold the output for a long stretch while words pour in back to back
                if (ph == 0 && i == 100)
                begin
                    drain();
                    hold_off_cycles = HOLD_CYCLES;
                    snd_idle = 0;
                end
                if (ph == 0 && i == 100 + BURST_ITEMS)
                begin
                    snd_idle = phase_snd[ph];
                end
                send_random();
            end
            drain();
        end

        repeat (2 * ptc_pkg::NUM_STAGES) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("tb_pressure_temperature_compensation passed");
        end
        else
        begin
            $display("tb_pressure_temperature_compensation failed");
        end
        $finish;
    end

    // Give up if the run hangs
    initial
    begin : watchdog
        #10_000_000;
        $display("tb_pressure_temperature_compensation failed");
        $finish;
    end

endmodule
